>>> sv/tvss_pkg.sv
// ----------------------------------------------------------------------------
// tvss_pkg
// Shared types and constants of the two-value seven-segment scanner.
// ----------------------------------------------------------------------------
package tvss_pkg;

    typedef struct packed {
        logic        command;
        logic [15:0] value_left;
        logic [15:0] value_right;
    } t_in_item;

    typedef struct packed {
        logic        latch_level;
        logic        word_valid;
        logic [15:0] segment_word;
    } t_out_item;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [15:0] DOT_MASK  = 16'h7FFF;
    localparam logic [15:0] FULL_MASK = 16'hFFFF;
    localparam logic [1:0]  DOT_POS   = 2'd1;
    localparam logic [7:0]  SEL_LEFT  = 8'h10;
    localparam logic [7:0]  SEL_RIGHT = 8'h01;

    // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for every 16-bit x
    localparam logic [32:0] DIV10_MUL   = 33'd52429;
    localparam int          DIV10_SHIFT = 19;

    function automatic logic [15:0] seg_pattern(input logic [3:0] digit);
        logic [15:0] pat;
        unique case (digit)
            4'd0:    pat = 16'hC000;
            4'd1:    pat = 16'hF900;
            4'd2:    pat = 16'hA400;
            4'd3:    pat = 16'hB000;
            4'd4:    pat = 16'h9900;
            4'd5:    pat = 16'h9200;
            4'd6:    pat = 16'h8200;
            4'd7:    pat = 16'hF800;
            4'd8:    pat = 16'h8000;
            4'd9:    pat = 16'h9000;
            default: pat = 16'h0000;
        endcase
        return pat;
    endfunction

endpackage

>>> sv/two_value_seven_segment_scanner.sv
// ----------------------------------------------------------------------------
// two_value_seven_segment_scanner
// Converts two display values into eight stored segment words and scans them.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall, payload i_in) takes load and tick
// items. A load splits each value into its low four decimal digits, one digit
// per cycle in a divide-by-ten unit per half, and writes one entry of each of
// two 4x16 word memories per cycle; the input stalls until all four are written.
// Ticks may follow each other in every cycle unless a load or the output stalls them.
// Output channel (o_out_valid / i_out_stall, payload o_out) carries one result
// per tick, through the memory read stage and then the output register.
// A raising tick returns latch_level 1 and word 0; a lowering tick returns
// latch_level 0, word_valid 1 and the stored word of the current position.
// Loads return nothing. While the receiver stalls, the output register and
// one read stage hold results; the input stalls once both are full.
// Reset clears the scan position, the latch phase and the entry valid bits,
// so words never loaded read as zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module two_value_seven_segment_scanner (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tvss_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tvss_pkg::t_out_item o_out
);
    import tvss_pkg::*;

    logic        r_busy;
    logic [1:0]  r_step;
    logic [15:0] r_x_l;
    logic [15:0] r_x_r;
    logic [3:0]  r_vld_l;
    logic [3:0]  r_vld_r;
    logic [15:0] r_mem_l [4];
    logic [15:0] r_mem_r [4];

    logic        r_phase;
    logic [2:0]  r_pos;

    logic        r_s1_valid;
    logic        r_s1_latch;
    logic        r_s1_wv;
    logic        r_s1_hi;
    logic [15:0] r_rd_l;
    logic [15:0] r_rd_r;
    logic        r_rd_vl;
    logic        r_rd_vr;

    logic        r_out_valid;
    t_out_item   r_out;

    logic        w_s1_move;
    logic        w_in_stall;
    logic        w_accept;
    logic        w_load;
    logic        w_tick;
    logic [32:0] w_prod_l;
    logic [32:0] w_prod_r;
    logic [15:0] w_q_l;
    logic [15:0] w_q_r;
    logic [3:0]  w_dig_l;
    logic [3:0]  w_dig_r;
    logic [15:0] w_mask;
    logic [15:0] w_word_l;
    logic [15:0] w_word_r;
    t_out_item   w_s1_item;

    always_comb begin
        w_s1_move  = !r_out_valid || !i_out_stall;
        w_in_stall = r_busy || (r_s1_valid && !w_s1_move);
        w_accept   = i_in_valid && !w_in_stall;
        w_load     = w_accept && (i_in.command == CMD_LOAD);
        w_tick     = w_accept && (i_in.command == CMD_TICK);
    end

    always_comb begin
        w_prod_l = {17'd0, r_x_l} * DIV10_MUL;
        w_prod_r = {17'd0, r_x_r} * DIV10_MUL;
        w_q_l    = 16'(w_prod_l >> DIV10_SHIFT);
        w_q_r    = 16'(w_prod_r >> DIV10_SHIFT);
        w_dig_l  = 4'(r_x_l - ((w_q_l << 3) + (w_q_l << 1)));
        w_dig_r  = 4'(r_x_r - ((w_q_r << 3) + (w_q_r << 1)));
        w_mask   = (r_step == DOT_POS) ? DOT_MASK : FULL_MASK;
        w_word_l = (seg_pattern(w_dig_l) & w_mask) + {8'h00, 8'(SEL_LEFT << r_step)};
        w_word_r = (seg_pattern(w_dig_r) & w_mask) + {8'h00, 8'(SEL_RIGHT << r_step)};
    end

    always_comb begin
        w_s1_item.latch_level  = r_s1_latch;
        w_s1_item.word_valid   = r_s1_wv;
        w_s1_item.segment_word = 16'h0000;
        if (r_s1_wv) begin
            if (r_s1_hi) begin
                w_s1_item.segment_word = r_rd_vr ? r_rd_r : 16'h0000;
            end else begin
                w_s1_item.segment_word = r_rd_vl ? r_rd_l : 16'h0000;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= 2'd0;
            r_vld_l     <= 4'd0;
            r_vld_r     <= 4'd0;
            r_phase     <= 1'b0;
            r_pos       <= 3'd0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_step <= 2'd3;
            end else if (r_busy) begin
                r_vld_l[r_step] <= 1'b1;
                r_vld_r[r_step] <= 1'b1;
                r_step          <= r_step - 2'd1;
                if (r_step == 2'd0) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_tick) begin
                r_phase <= !r_phase;
                if (r_phase) begin
                    r_pos <= r_pos + 3'd1;
                end
            end
            if (w_tick) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // digit unit and word memories
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_x_l <= i_in.value_left;
            r_x_r <= i_in.value_right;
        end else if (r_busy) begin
            r_x_l            <= w_q_l;
            r_x_r            <= w_q_r;
            r_mem_l[r_step]  <= w_word_l;
            r_mem_r[r_step]  <= w_word_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_rd_l     <= r_mem_l[r_pos[1:0]];
            r_rd_r     <= r_mem_r[r_pos[1:0]];
            r_rd_vl    <= r_vld_l[r_pos[1:0]];
            r_rd_vr    <= r_vld_r[r_pos[1:0]];
            r_s1_latch <= !r_phase;
            r_s1_wv    <= r_phase;
            r_s1_hi    <= r_pos[2];
        end
        if (r_s1_valid && w_s1_move) begin
            r_out <= w_s1_item;
        end
    end

    assign o_in_stall  = w_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> sv/tvss_checker.sv
// ----------------------------------------------------------------------------
// tvss_checker
// Port-level checks of the scanner's result channel.
// ----------------------------------------------------------------------------
module tvss_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tvss_pkg::t_out_item o_out
);
    import tvss_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

    a_word_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.word_valid) |-> !o_out.latch_level)
        else $error("word transfer with latch high");

    a_raise_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.word_valid) |->
            (o_out.latch_level && (o_out.segment_word == 16'h0000)))
        else $error("raising tick carries a word");

    a_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.word_valid) |-> $onehot0(o_out.segment_word[7:0]))
        else $error("digit select not one-hot");

endmodule

bind two_value_seven_segment_scanner tvss_checker u_tvss_checker (.*);

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and scan-tick transfers into the scanner with random idling on
// both channels and compares every returned word with the local predictor or a row's want.
// ----------------------------------------------------------------------------
module testbench;
    import tvss_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int TAIL_CYCLES  = 8;
    localparam int REPORT_LIMIT = 10;

    localparam logic [15:0] DIGIT_GLYPH [10] = '{
        16'hC000, 16'hF900, 16'hA400, 16'hB000, 16'h9900,
        16'h9200, 16'h8200, 16'hF800, 16'h8000, 16'h9000
    };
    localparam logic [15:0] POINT_CLEAR = 16'h7FFF;

    localparam t_in_item  TICK    = '{CMD_TICK, 16'h0000, 16'h0000};
    localparam t_out_item NO_WORD = '0;
    localparam t_out_item RAISE   = '{1'b1, 1'b0, 16'h0000};
    localparam t_out_item LOWER_0 = '{1'b0, 1'b1, 16'h0000};

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 24;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    logic [15:0] scan_words [8];
    logic [2:0]  scan_pos;
    logic        latch_high;

    t_out_item pending_words[$];
    int        error_count;
    int        mismatch_count;
    int        cycle_count;
    bit        calm_stretch;

    two_value_seven_segment_scanner u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void store_digits(input logic [15:0] value, input int base,
                                         input logic [7:0] first_sel);
        int          rest;
        logic [15:0] glyph;
        rest = int'(value) % 10000;
        for (int k = 3; k >= 0; k--) begin
            glyph = DIGIT_GLYPH[rest % 10];
            rest  = rest / 10;
            if (k == 1) begin
                glyph = glyph & POINT_CLEAR;
            end
            scan_words[base + k] = glyph + ({8'h00, first_sel} << k);
        end
    endfunction

    function automatic bit predict_scan(input t_in_item item, output t_out_item word);
        word = NO_WORD;
        if (item.command == CMD_LOAD) begin
            store_digits(item.value_left, 0, 8'h10);
            store_digits(item.value_right, 4, 8'h01);
            return 1'b0;
        end
        if (latch_high) begin
            latch_high        = 1'b0;
            word.latch_level  = 1'b0;
            word.word_valid   = 1'b1;
            word.segment_word = scan_words[scan_pos];
            scan_pos          = scan_pos + 3'd1;
        end else begin
            latch_high       = 1'b1;
            word.latch_level = 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic send_item(input t_in_item item, input bit typed, input t_out_item want);
        t_out_item word;
        while (!calm_stretch && $urandom_range(0, 99) < 11) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge i_clk);
        while (in_stall) begin
            @(posedge i_clk);
        end
        if (predict_scan(item, word)) begin
            pending_words.push_back(typed ? want : word);
        end
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd9999;
            2:       return 16'd10000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("two_value_seven_segment_scanner: mismatch");
            $finish;
        end
    end

    initial begin
        out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            out_stall <= !calm_stretch && ($urandom_range(0, 99) < 11);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_words.size() == 0) begin
                error_count++;
                if (error_count + mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected transfer: got %p", out_item);
                end
            end else begin
                want = pending_words.pop_front();
                if (out_item.latch_level !== want.latch_level ||
                    out_item.word_valid !== want.word_valid ||
                    out_item.segment_word !== want.segment_word) begin
                    mismatch_count++;
                    if (error_count + mismatch_count <= REPORT_LIMIT) begin
                        $display("word mismatch: expected %b %b %h, got %b %b %h",
                                 want.latch_level, want.word_valid, want.segment_word,
                                 out_item.latch_level, out_item.word_valid,
                                 out_item.segment_word);
                    end
                end
            end
        end
    end

    initial begin
        t_stim_row directed_rows [DIRECTED_ROWS];
        t_in_item  item;

        directed_rows = '{
            '{TICK, 1'b1, RAISE},
            '{TICK, 1'b1, LOWER_0},
            '{'{CMD_LOAD, 16'hFFFF, 16'h0000}, 1'b0, NO_WORD},
            '{TICK, 1'b0, NO_WORD},
            '{TICK, 1'b0, NO_WORD},
            '{'{CMD_LOAD, 16'd9999, 16'd10000}, 1'b0, NO_WORD},
            '{TICK, 1'b0, NO_WORD}, '{TICK, 1'b0, NO_WORD},
            '{TICK, 1'b0, NO_WORD}, '{TICK, 1'b0, NO_WORD},
            '{TICK, 1'b0, NO_WORD}, '{TICK, 1'b0, NO_WORD},
            '{TICK, 1'b0, NO_WORD}, '{TICK, 1'b0, NO_WORD},
            '{TICK, 1'b0, NO_WORD}, '{TICK, 1'b0, NO_WORD},
            '{TICK, 1'b0, NO_WORD}, '{TICK, 1'b0, NO_WORD},
            '{'{CMD_LOAD, 16'd1234, 16'd5678}, 1'b0, NO_WORD},
            '{TICK, 1'b0, NO_WORD}, '{TICK, 1'b0, NO_WORD},
            '{TICK, 1'b0, NO_WORD}, '{TICK, 1'b0, NO_WORD},
            '{'{CMD_LOAD, 16'h0000, 16'hFFFF}, 1'b0, NO_WORD}
        };

        i_rst_n        <= 1'b0;
        in_valid       <= 1'b0;
        in_item        <= '0;
        calm_stretch    = 1'b0;
        for (int k = 0; k < 8; k++) begin
            scan_words[k] = 16'h0000;
        end
        scan_pos   = 3'd0;
        latch_high = 1'b0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm_stretch = (n >= 500 && n < 800);
            if (n == 900) begin
                while (pending_words.size() != 0) begin
                    in_valid <= 1'b0;
                    @(negedge i_clk);
                end
            end
            item.command     = ($urandom_range(0, 99) < 20) ? CMD_LOAD : CMD_TICK;
            item.value_left  = pick_value();
            item.value_right = pick_value();
            send_item(item, 1'b0, NO_WORD);
        end

        in_valid     <= 1'b0;
        calm_stretch  = 1'b0;
        while (pending_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (error_count == 0 && mismatch_count == 0 && pending_words.size() == 0) begin
            $display("two_value_seven_segment_scanner: match");
        end else begin
            $display("two_value_seven_segment_scanner: mismatch");
        end
        $finish;
    end
endmodule
